// ===== rtl/core/bsva_pkg.sv =====
// Shared constants for the burst sync verify aligner.
package bsva_pkg;

	localparam int BURST_BITS_DEF      = 264;
	localparam int BITS_AFTER_SYNC_DEF = 108;
	localparam int QUEUE_DEPTH         = 2;

	localparam int SINCE_W = 10;
	localparam int TOL_W   = 4;
	localparam int KIND_W  = 4;
	localparam int IDX_W   = 6;

	localparam logic [SINCE_W-1:0] SINCE_MAX = 10'd1023;
	localparam logic [TOL_W-1:0]   TOL_RESET = 4'd1;

endpackage

// ===== rtl/core/bsva_front.sv =====
// Front end: bit history, sync position checking, lock tracking and burst capture.
module bsva_front import bsva_pkg::*; #(
	parameter int BURST_BITS      = BURST_BITS_DEF,
	parameter int BITS_AFTER_SYNC = BITS_AFTER_SYNC_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         rx_bit,
	input  logic                         sync_hit,
	input  logic [KIND_W-1:0]            sync_kind,
	input  logic [TOL_W-1:0]             tolerance,
	output logic                         push,
	output logic [BURST_BITS+KIND_W-1:0] push_data
);

	localparam int FILL_W = $clog2(BURST_BITS + 1);
	localparam int CD_W   = $clog2(BITS_AFTER_SYNC + 1);

	logic [BURST_BITS-1:0] hist_q, hist_n;
	logic [FILL_W-1:0]     fill_q, fill_n;
	logic [SINCE_W-1:0]    since_q, since_n, pos_err;
	logic                  anchor_q, lock_q, lock_n, armed_q, armed_n;
	logic [CD_W-1:0]       cd_q, cd_n;
	logic [KIND_W-1:0]     kind_q, kind_n;
	logic                  completed, near, on_time;

	always_comb begin
		// The newest bit enters at the bottom, so the oldest bit sits at the top.
		hist_n = {hist_q[BURST_BITS-2:0], rx_bit};
		fill_n = (fill_q == FILL_W'(BURST_BITS)) ? fill_q : fill_q + 1'b1;
		since_n = (since_q < SINCE_MAX) ? since_q + 1'b1 : since_q;

		cd_n = cd_q;
		armed_n = armed_q;
		completed = 1'b0;
		if (armed_q && cd_q != '0) begin
			cd_n = cd_q - 1'b1;
			if (cd_n == '0) begin
				completed = 1'b1;
				armed_n = 1'b0;
			end
		end

		pos_err = (since_n >= SINCE_W'(BURST_BITS)) ? since_n - SINCE_W'(BURST_BITS)
		                                            : SINCE_W'(BURST_BITS) - since_n;
		near = pos_err <= SINCE_W'(tolerance);
		// The lock only exists behind an anchor, so this covers keep and confirm.
		on_time = anchor_q && near;

		lock_n = lock_q;
		kind_n = kind_q;
		if (sync_hit) begin
			if (on_time) begin
				lock_n = 1'b1;
				cd_n = CD_W'(BITS_AFTER_SYNC);
				armed_n = 1'b1;
				kind_n = sync_kind;
			end else begin
				lock_n = 1'b0;
				cd_n = '0;
				armed_n = 1'b0;
			end
		end
	end

	assign push = accept && completed && lock_n && (fill_n == FILL_W'(BURST_BITS));
	assign push_data = {kind_n, hist_n};

	always_ff @(posedge clk) begin
		if (accept) begin
			hist_q <= hist_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			since_q <= '0;
			anchor_q <= 1'b0;
			lock_q <= 1'b0;
			cd_q <= '0;
			armed_q <= 1'b0;
			kind_q <= '0;
		end else if (accept) begin
			fill_q <= fill_n;
			since_q <= sync_hit ? '0 : since_n;
			anchor_q <= anchor_q | sync_hit;
			lock_q <= lock_n;
			cd_q <= cd_n;
			armed_q <= armed_n;
			kind_q <= kind_n;
		end
	end

	a_lock_needs_anchor: assert property (@(posedge clk) disable iff (!arst_n)
		lock_q |-> anchor_q) else $error("lock held without an anchor");

	a_armed_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> (cd_q != '0)) else $error("countdown armed at zero");

endmodule

// ===== rtl/core/bsva_fifo.sv =====
// Short queue of captured bursts between the front end and the byte drain.
module bsva_fifo import bsva_pkg::*; #(
	parameter int WIDTH = BURST_BITS_DEF + KIND_W,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             full,
	output logic             not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	assign full = cnt_q == CW'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop)) else $error("burst queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("burst queue underflow");

endmodule

// ===== rtl/core/bsva_back.sv =====
// Byte drain: unpacks one captured burst into bytes, oldest bit first.
module bsva_back import bsva_pkg::*; #(
	parameter int BURST_BITS = BURST_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [BURST_BITS+KIND_W-1:0] head,
	input  logic                         not_empty,
	output logic                         pop,
	output logic                         byte_valid,
	input  logic                         byte_stall,
	output logic [7:0]                   burst_byte,
	output logic [IDX_W-1:0]             byte_index,
	output logic                         last_byte,
	output logic [KIND_W-1:0]            burst_kind
);

	localparam int NBYTES = BURST_BITS / 8;

	logic [BURST_BITS-1:0] sh_q;
	logic [IDX_W-1:0]      idx_q;
	logic [KIND_W-1:0]     kind_q;
	logic                  busy_q;
	logic                  take;

	assign byte_valid = busy_q;
	assign burst_byte = sh_q[BURST_BITS-1 -: 8];
	assign byte_index = idx_q;
	assign last_byte = idx_q == IDX_W'(NBYTES - 1);
	assign burst_kind = kind_q;

	assign take = busy_q && !byte_stall;
	// A new burst loads in the same cycle the last byte of the old one leaves.
	assign pop = not_empty && (!busy_q || (take && last_byte));

	always_ff @(posedge clk) begin
		if (pop) begin
			sh_q <= head[BURST_BITS-1:0];
			kind_q <= head[BURST_BITS+KIND_W-1:BURST_BITS];
		end else if (take) begin
			sh_q <= {sh_q[BURST_BITS-9:0], 8'h00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (take) begin
			if (last_byte) begin
				busy_q <= 1'b0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q < IDX_W'(NBYTES))) else $error("byte index past burst end");

endmodule

// ===== rtl/core/burst_sync_verify_aligner.sv =====
// Burst sync verify aligner: one received bit per item in, verified bursts out as bytes.
//
// Each accepted item carries one received bit plus the sync hit flag and sync type from an
// external correlator. The block keeps the last BURST_BITS bits and counts bits since the
// last sync hit. A hit that lands BURST_BITS bits after the previous one, give or take the
// position tolerance register (reset value 1), confirms or keeps the lock and starts a
// countdown of BITS_AFTER_SYNC bits; any other hit drops the lock and becomes the new
// reference point. When the countdown runs out while locked and the history is full, the
// history is captured and sent out as BURST_BITS/8 bytes, oldest bit in bit 7 of byte 0,
// each byte tagged with its index, a last flag and the sync type. Input items are taken
// at one per cycle with no pause on the cycle that captures a burst. The byte side emits
// one byte per cycle while byte_stall is low; captured bursts wait in a two-entry queue
// behind the byte drain register, and the input side stalls only while that queue is
// full, which happens only when the byte consumer holds off for long.
// The tolerance register should be written only while no burst is pending.
module burst_sync_verify_aligner import bsva_pkg::*; #(
	parameter int BURST_BITS      = BURST_BITS_DEF,
	parameter int BITS_AFTER_SYNC = BITS_AFTER_SYNC_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [TOL_W-1:0]  cfg_wdata,
	input  logic              bit_valid,
	output logic              bit_stall,
	input  logic              rx_bit,
	input  logic              sync_hit,
	input  logic [KIND_W-1:0] sync_kind,
	output logic              byte_valid,
	input  logic              byte_stall,
	output logic [7:0]        burst_byte,
	output logic [IDX_W-1:0]  byte_index,
	output logic              last_byte,
	output logic [KIND_W-1:0] burst_kind
);

	localparam int EW = BURST_BITS + KIND_W;

	logic [TOL_W-1:0] tolerance_q;
	logic             bit_accept;
	logic             push, pop, full, not_empty;
	logic [EW-1:0]    push_data, head;

	// Position tolerance, the only configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= TOL_RESET;
		end else if (cfg_wen) begin
			tolerance_q <= cfg_wdata;
		end
	end

	// Holding off whenever the queue is full keeps a capture from ever being dropped.
	assign bit_stall = full;
	assign bit_accept = bit_valid && !full;

	bsva_front #(
		.BURST_BITS      (BURST_BITS),
		.BITS_AFTER_SYNC (BITS_AFTER_SYNC)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (bit_accept),
		.rx_bit    (rx_bit),
		.sync_hit  (sync_hit),
		.sync_kind (sync_kind),
		.tolerance (tolerance_q),
		.push      (push),
		.push_data (push_data)
	);

	bsva_fifo #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.not_empty (not_empty)
	);

	bsva_back #(
		.BURST_BITS (BURST_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.not_empty  (not_empty),
		.pop        (pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.burst_byte (burst_byte),
		.byte_index (byte_index),
		.last_byte  (last_byte),
		.burst_kind (burst_kind)
	);

endmodule

// ===== bench/bsva_burst_checker.sv =====
// Checker that predicts every burst of the aligner and compares each emitted byte.
module bsva_burst_checker import bsva_pkg::*; #(
	parameter int BURST_BITS      = BURST_BITS_DEF,
	parameter int BITS_AFTER_SYNC = BITS_AFTER_SYNC_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [TOL_W-1:0]  cfg_wdata,
	input  logic              bit_valid,
	input  logic              bit_stall,
	input  logic              rx_bit,
	input  logic              sync_hit,
	input  logic [KIND_W-1:0] sync_kind,
	input  logic              byte_valid,
	input  logic              byte_stall,
	input  logic [7:0]        burst_byte,
	input  logic [IDX_W-1:0]  byte_index,
	input  logic              last_byte,
	input  logic [KIND_W-1:0] burst_kind,
	output int                mismatches,
	output int                bytes_pending,
	output int                bursts_predicted,
	output int                bytes_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBYTES = BURST_BITS / 8;

	typedef struct {
		logic [7:0]        value;
		logic [IDX_W-1:0]  index;
		logic              last;
		logic [KIND_W-1:0] kind;
	} burst_byte_t;

	burst_byte_t bytes_due[$];

	// Predicted framer state, kept at the widths of the block.
	logic [TOL_W-1:0]      tolerance;
	logic [BURST_BITS-1:0] history;
	logic [8:0]            fill;
	logic [SINCE_W-1:0]    since_sync;
	logic                  anchored;
	logic                  locked;
	logic [6:0]            countdown;
	logic                  armed;
	logic [KIND_W-1:0]     armed_kind;

	int err_count   = 0;
	int burst_total = 0;
	int byte_total  = 0;

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
		err_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : framer_model
		burst_byte_t want;
		logic [7:0]  packed_byte;
		logic        completed;
		int          slip;
		int          k;
		int          j;
		if (!arst_n) begin
			tolerance  = TOL_RESET;
			history    = '0;
			fill       = '0;
			since_sync = '0;
			anchored   = 1'b0;
			locked     = 1'b0;
			countdown  = '0;
			armed      = 1'b0;
			armed_kind = '0;
			bytes_due.delete();
			bytes_pending    <= 0;
			bursts_predicted <= burst_total;
			mismatches       <= err_count;
			bytes_checked    <= byte_total;
		end else begin
			// Outputs leaving at this edge belong to items accepted earlier, so check them first.
			if (byte_valid && !byte_stall) begin
				if (bytes_due.size() == 0) begin
					report_mismatch("byte with nothing expected, value", burst_byte, -1);
				end else begin
					want = bytes_due.pop_front();
					byte_total++;
					if (burst_byte !== want.value)
						report_mismatch("burst_byte", burst_byte, want.value);
					if (byte_index !== want.index)
						report_mismatch("byte_index", byte_index, want.index);
					if (last_byte !== want.last)
						report_mismatch("last_byte", last_byte, want.last);
					if (burst_kind !== want.kind)
						report_mismatch("burst_kind", burst_kind, want.kind);
				end
			end

			if (cfg_wen)
				tolerance = cfg_wdata;

			if (bit_valid && !bit_stall) begin
				completed = 1'b0;
				// The history holds the oldest bit at index 0.
				if (fill < BURST_BITS) begin
					history[fill] = rx_bit;
					fill++;
				end else begin
					history = {rx_bit, history[BURST_BITS-1:1]};
				end
				if (since_sync != SINCE_MAX)
					since_sync++;
				if (armed && countdown != 0) begin
					countdown--;
					if (countdown == 0) begin
						completed = 1'b1;
						armed     = 1'b0;
					end
				end
				if (sync_hit) begin
					slip = (int'(since_sync) > BURST_BITS) ? int'(since_sync) - BURST_BITS
						: BURST_BITS - int'(since_sync);
					if ((locked || anchored) && slip <= int'(tolerance)) begin
						locked     = 1'b1;
						countdown  = 7'(BITS_AFTER_SYNC);
						armed      = 1'b1;
						armed_kind = sync_kind;
					end else begin
						locked    = 1'b0;
						countdown = '0;
						armed     = 1'b0;
					end
					anchored   = 1'b1;
					since_sync = '0;
				end
				if (completed && locked && fill == BURST_BITS) begin
					for (k = 0; k < NBYTES; k++) begin
						for (j = 0; j < 8; j++)
							packed_byte[7-j] = history[k*8+j];
						want.value = packed_byte;
						want.index = IDX_W'(k);
						want.last  = (k == NBYTES - 1);
						want.kind  = armed_kind;
						bytes_due.insert(bytes_due.size(), want);
					end
					burst_total++;
				end
			end

			bytes_pending    <= bytes_due.size();
			bursts_predicted <= burst_total;
			mismatches       <= err_count;
			bytes_checked    <= byte_total;
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// Top of the aligner testbench: clock, reset, stimulus, output back-pressure and the verdict.
module tb_top;
	import bsva_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PERIOD          = 8;
	localparam int RESET_CYCLES    = 9;
	localparam int CYCLE_LIMIT     = 1_000_000;
	// The long output hold must outlast several burst periods so the capture queue fills.
	localparam int HOLD_CYCLES     = 2000;
	localparam int PRESSURE_FRAMES = 10;
	// Cycles allowed after the last byte for the block to settle before a register write.
	localparam int SETTLE_CYCLES   = 16;
	localparam int PHASE_BURSTS    = 3;
	localparam int PHASE_FRAME_CAP = 80;
	localparam int NOISE_ITEMS     = 30;
	localparam int DIRECTED_ITEMS  = 22;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_wen;
	logic [TOL_W-1:0]  cfg_wdata;
	logic              bit_valid;
	logic              bit_stall;
	logic              rx_bit;
	logic              sync_hit;
	logic [KIND_W-1:0] sync_kind;
	logic              byte_valid;
	logic              byte_stall;
	logic [7:0]        burst_byte;
	logic [IDX_W-1:0]  byte_index;
	logic              last_byte;
	logic [KIND_W-1:0] burst_kind;

	int mismatches;
	int bytes_pending;
	int bursts_predicted;
	int bytes_checked;

	int               items_sent = 0;
	int               cycle_count = 0;
	logic [TOL_W-1:0] tol_now = TOL_RESET;
	logic [TOL_W-1:0] mid_tol;
	bit               sender_gaps = 1'b1;
	bit               receiver_stalls = 1'b1;
	bit               hold_req = 1'b0;

	always #(PERIOD/2) clk = ~clk;

	burst_sync_verify_aligner uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.bit_valid  (bit_valid),
		.bit_stall  (bit_stall),
		.rx_bit     (rx_bit),
		.sync_hit   (sync_hit),
		.sync_kind  (sync_kind),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.burst_byte (burst_byte),
		.byte_index (byte_index),
		.last_byte  (last_byte),
		.burst_kind (burst_kind)
	);

	bsva_burst_checker burst_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wen          (cfg_wen),
		.cfg_wdata        (cfg_wdata),
		.bit_valid        (bit_valid),
		.bit_stall        (bit_stall),
		.rx_bit           (rx_bit),
		.sync_hit         (sync_hit),
		.sync_kind        (sync_kind),
		.byte_valid       (byte_valid),
		.byte_stall       (byte_stall),
		.burst_byte       (burst_byte),
		.byte_index       (byte_index),
		.last_byte        (last_byte),
		.burst_kind       (burst_kind),
		.mismatches       (mismatches),
		.bytes_pending    (bytes_pending),
		.bursts_predicted (bursts_predicted),
		.bytes_checked    (bytes_checked)
	);

	// Idle and stall lengths drawn at random, with now and then a long stretch.
	function automatic int gap_len();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(12, 60);
	endfunction

	// Offers one item and returns once it has been accepted. Valid stays high afterwards,
	// so back-to-back items need no extra assignment; the next call either refreshes the
	// payload or lowers valid for a gap.
	task automatic send_item(input logic b, input logic h, input logic [KIND_W-1:0] k);
		if (sender_gaps && $urandom_range(0, 9) < 3) begin
			bit_valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
		bit_valid <= 1'b1;
		rx_bit    <= b;
		sync_hit  <= h;
		sync_kind <= k;
		@(posedge clk);
		while (bit_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// A frame is len bits with the sync hit on the last one, so the hit lands exactly
	// len bits after the previous hit.
	task automatic send_frame(input int len);
		int i;
		for (i = 1; i < len; i++)
			send_item(1'($urandom_range(0, 1)), 1'b0, KIND_W'($urandom_range(0, 15)));
		send_item(1'($urandom_range(0, 1)), 1'b1, KIND_W'($urandom_range(0, 15)));
	endtask

	// Stops offering items and waits until every predicted byte has come out, then waits
	// out the settle time in case the block is still busy with an item that emits nothing.
	task automatic wait_idle();
		bit_valid <= 1'b0;
		@(posedge clk);
		while (bytes_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic [TOL_W-1:0] value);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		tol_now = value;
	endtask

	// One phase at a fixed tolerance. Most frames are well-formed bursts with a slip inside
	// the tolerance, which lock and emit; the rest break the lock in the ways that matter:
	// a slip just outside the window, an early hit, a hit on the very bit where the
	// countdown expires, an anchor so old the distance counter saturates, and plain noise.
	task automatic run_phase(input logic [TOL_W-1:0] value, input bit idling);
		int start_bursts;
		int frames;
		int pick;
		int slip;
		int i;
		wait_idle();
		write_tolerance(value);
		sender_gaps     = idling;
		receiver_stalls = idling;
		start_bursts    = bursts_predicted;
		frames          = 0;
		while (bursts_predicted - start_bursts < PHASE_BURSTS && frames < PHASE_FRAME_CAP) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				slip = $urandom_range(0, 2 * tol_now) - int'(tol_now);
				send_frame(BURST_BITS_DEF + slip);
			end else if (pick < 75) begin
				slip = int'(tol_now) + $urandom_range(1, 4);
				send_frame(($urandom_range(0, 1) != 0) ? BURST_BITS_DEF + slip
					: BURST_BITS_DEF - slip);
			end else if (pick < 83) begin
				send_frame($urandom_range(1, 200));
			end else if (pick < 88) begin
				// Lands on the bit where a burst armed by the previous hit would complete.
				send_frame(BITS_AFTER_SYNC_DEF);
			end else if (pick < 91) begin
				send_frame($urandom_range(1030, 1100));
			end else begin
				for (i = 0; i < NOISE_ITEMS; i++)
					send_item(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
						KIND_W'($urandom_range(0, 15)));
			end
			// Now and then the sender pauses until the output side has fully drained.
			if ($urandom_range(0, 99) < 4)
				wait_idle();
			frames++;
		end
	endtask

	// Output side: random stall stretches, or one long hold on request, counted here.
	initial begin
		byte_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				byte_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_req = 1'b0;
			end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
				byte_stall <= 1'b1;
				repeat (gap_len() - 1) @(posedge clk);
			end else begin
				byte_stall <= 1'b0;
			end
		end
	end

	// Watchdog: a run that hangs ends here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles without finishing.", cycle_count);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int i;
		arst_n    = 1'b0;
		cfg_wen   = 1'b0;
		cfg_wdata = '0;
		bit_valid = 1'b0;
		rx_bit    = 1'b0;
		sync_hit  = 1'b0;
		sync_kind = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed start at zero tolerance: both bit values, the extreme sync codes, the very
		// first hit that only sets an anchor, a hit far too early, and two hits in a row.
		// None of these can emit, since the history is not yet full.
		write_tolerance('0);
		for (i = 0; i < DIRECTED_ITEMS; i++)
			send_item(i[0] ^ i[2], (i == 2 || i == 8 || i == 9 || i == 20),
				(i[0] != 0) ? KIND_W'(15) : KIND_W'(0));

		// Random phases: widest window with idling, exact window with no idling at all,
		// a random window in between, and the reset value.
		mid_tol = TOL_W'($urandom_range(2, 14));
		run_phase(4'd15, 1'b1);
		run_phase(4'd0, 1'b0);
		run_phase(mid_tol, 1'b1);
		run_phase(TOL_RESET, 1'b1);

		// Back-pressure: the output side holds off for a long stretch while a locked stream
		// keeps coming at full rate, so captured bursts pile up and the input must stall.
		wait_idle();
		sender_gaps = 1'b0;
		hold_req    = 1'b1;
		repeat (PRESSURE_FRAMES) send_frame(BURST_BITS_DEF);

		wait_idle();
		$display("Covered %0d bit items over tolerances 0, 15, %0d and 1, plus a long output hold.",
			items_sent, mid_tol);
		$display("Predicted %0d bursts and compared %0d bytes field by field.",
			bursts_predicted, bytes_checked);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
